// File: rtl/assert_macros.svh
// Assertion macros shared by the clipper RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Free-form property, disabled while reset is asserted.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("property check failed");

`endif

// File: rtl/lsw_pkg.sv
// Shared types and constants of the segment clipper.
// No dependencies; imported by lsw_edge, lsw_ratio and the top level.
`default_nettype none

package lsw_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN = 2'd0,
    REG_X_MAX = 2'd1,
    REG_Y_MIN = 2'd2,
    REG_Y_MAX = 2'd3
  } lsw_reg_e;

  // Per-stage control that travels with the data.
  typedef struct packed {
    logic valid;
    logic reject;
  } lsw_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/lsw_edge.sv
// First stage: edge terms, per-axis entry and exit ratios, parallel-edge reject.
// Depends on lsw_pkg.
`default_nettype none

module lsw_edge #(
  parameter int unsigned N = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [N-1:0]     xa_i,
  input  logic signed [N-1:0]     ya_i,
  input  logic signed [N-1:0]     xb_i,
  input  logic signed [N-1:0]     yb_i,
  input  logic signed [N-1:0]     x_min_i,
  input  logic signed [N-1:0]     x_max_i,
  input  logic signed [N-1:0]     y_min_i,
  input  logic signed [N-1:0]     y_max_i,
  output lsw_pkg::lsw_ctrl_t      ctrl_o,
  output logic signed [N-1:0]     xa_o,
  output logic signed [N-1:0]     ya_o,
  output logic signed [N:0]       dx_o,
  output logic signed [N:0]       dy_o,
  output logic signed [N+1:0]     enx_n_o,
  output logic signed [N+1:0]     exx_n_o,
  output logic signed [N+1:0]     eny_n_o,
  output logic signed [N+1:0]     exy_n_o,
  output logic [N-1:0]            dx_d_o,
  output logic [N-1:0]            dy_d_o
);
  import lsw_pkg::*;

  localparam int unsigned NW = N + 2;

  logic signed [N:0]    dx, dy, ndx, ndy;
  logic signed [NW-1:0] xa_w, ya_w, xmin_w, xmax_w, ymin_w, ymax_w;
  logic signed [NW-1:0] enx_n, exx_n, eny_n, exy_n;
  logic [N-1:0]         dx_d, dy_d;
  logic                 rej_x, rej_y;
  lsw_ctrl_t            ctrl_d, ctrl_q;

  assign dx  = {xb_i[N-1], xb_i} - {xa_i[N-1], xa_i};
  assign dy  = {yb_i[N-1], yb_i} - {ya_i[N-1], ya_i};
  assign ndx = -dx;
  assign ndy = -dy;

  assign xa_w   = NW'(xa_i);
  assign ya_w   = NW'(ya_i);
  assign xmin_w = NW'(x_min_i);
  assign xmax_w = NW'(x_max_i);
  assign ymin_w = NW'(y_min_i);
  assign ymax_w = NW'(y_max_i);

  // A parallel axis imposes no ratio: entry stays 0/1, exit stays 1/1.
  always_comb begin
    enx_n = '0;
    exx_n = NW'(1);
    dx_d  = N'(1);
    rej_x = 1'b0;
    if (dx > 0) begin
      enx_n = xmin_w - xa_w;
      exx_n = xmax_w - xa_w;
      dx_d  = dx[N-1:0];
    end else if (dx < 0) begin
      enx_n = xa_w - xmax_w;
      exx_n = xa_w - xmin_w;
      dx_d  = ndx[N-1:0];
    end else begin
      rej_x = (xa_i < x_min_i) || (xa_i > x_max_i);
    end
  end

  always_comb begin
    eny_n = '0;
    exy_n = NW'(1);
    dy_d  = N'(1);
    rej_y = 1'b0;
    if (dy > 0) begin
      eny_n = ymin_w - ya_w;
      exy_n = ymax_w - ya_w;
      dy_d  = dy[N-1:0];
    end else if (dy < 0) begin
      eny_n = ya_w - ymax_w;
      exy_n = ya_w - ymin_w;
      dy_d  = ndy[N-1:0];
    end else begin
      rej_y = (ya_i < y_min_i) || (ya_i > y_max_i);
    end
  end

  assign ctrl_d.valid  = valid_i;
  assign ctrl_d.reject = rej_x || rej_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xa_o    <= xa_i;
    ya_o    <= ya_i;
    dx_o    <= dx;
    dy_o    <= dy;
    enx_n_o <= enx_n;
    exx_n_o <= exx_n;
    eny_n_o <= eny_n;
    exy_n_o <= exy_n;
    dx_d_o  <= dx_d;
    dy_d_o  <= dy_d;
  end

  assign ctrl_o = ctrl_q;

endmodule

`default_nettype wire

// File: rtl/lsw_ratio.sv
// Second and third stages: cross-multiply the axis ratios, then pick the
// entry maximum and exit minimum, clamped to [0, 1]. Depends on lsw_pkg.
`default_nettype none

module lsw_ratio #(
  parameter int unsigned N = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lsw_pkg::lsw_ctrl_t      ctrl_i,
  input  logic signed [N-1:0]     xa_i,
  input  logic signed [N-1:0]     ya_i,
  input  logic signed [N:0]       dx_i,
  input  logic signed [N:0]       dy_i,
  input  logic signed [N+1:0]     enx_n_i,
  input  logic signed [N+1:0]     exx_n_i,
  input  logic signed [N+1:0]     eny_n_i,
  input  logic signed [N+1:0]     exy_n_i,
  input  logic [N-1:0]            dx_d_i,
  input  logic [N-1:0]            dy_d_i,
  output lsw_pkg::lsw_ctrl_t      ctrl_o,
  output logic signed [N-1:0]     xa_o,
  output logic signed [N-1:0]     ya_o,
  output logic signed [N:0]       dx_o,
  output logic signed [N:0]       dy_o,
  output logic signed [N+1:0]     en_num_o,
  output logic [N-1:0]            en_den_o,
  output logic signed [N+1:0]     ex_num_o,
  output logic [N-1:0]            ex_den_o
);
  import lsw_pkg::*;

  localparam int unsigned NW = N + 2;
  localparam int unsigned PW = 2 * NW;

  // Cross-product stage
  lsw_ctrl_t            ctrl2_q;
  logic signed [N-1:0]  xa2_q, ya2_q;
  logic signed [N:0]    dx2_q, dy2_q;
  logic signed [NW-1:0] enx2_q, exx2_q, eny2_q, exy2_q;
  logic [N-1:0]         dxd2_q, dyd2_q;
  logic signed [PW-1:0] pen_x_q, pen_y_q, pex_x_q, pex_y_q;
  logic signed [NW-1:0] dx_dw, dy_dw;

  // Selection stage
  lsw_ctrl_t            ctrl_q;
  logic signed [NW-1:0] en_num_d, ex_num_d, en_num_q, ex_num_q;
  logic [N-1:0]         en_den_d, ex_den_d, en_den_q, ex_den_q;
  logic signed [NW-1:0] en_pick_n, ex_pick_n, ex_pick_dw;
  logic [N-1:0]         en_pick_d, ex_pick_d;

  assign dx_dw = $signed({2'b00, dx_d_i});
  assign dy_dw = $signed({2'b00, dy_d_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl2_q <= '0;
      ctrl_q  <= '0;
    end else begin
      ctrl2_q <= ctrl_i;
      ctrl_q  <= ctrl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xa2_q   <= xa_i;
    ya2_q   <= ya_i;
    dx2_q   <= dx_i;
    dy2_q   <= dy_i;
    enx2_q  <= enx_n_i;
    exx2_q  <= exx_n_i;
    eny2_q  <= eny_n_i;
    exy2_q  <= exy_n_i;
    dxd2_q  <= dx_d_i;
    dyd2_q  <= dy_d_i;
    pen_x_q <= PW'(enx_n_i) * PW'(dy_dw);
    pen_y_q <= PW'(eny_n_i) * PW'(dx_dw);
    pex_x_q <= PW'(exx_n_i) * PW'(dy_dw);
    pex_y_q <= PW'(exy_n_i) * PW'(dx_dw);
  end

  // Take the larger entry and the smaller exit, then clamp to [0, 1].
  always_comb begin
    if (pen_x_q > pen_y_q) begin
      en_pick_n = enx2_q;
      en_pick_d = dxd2_q;
    end else begin
      en_pick_n = eny2_q;
      en_pick_d = dyd2_q;
    end
    if (pex_x_q < pex_y_q) begin
      ex_pick_n = exx2_q;
      ex_pick_d = dxd2_q;
    end else begin
      ex_pick_n = exy2_q;
      ex_pick_d = dyd2_q;
    end
    ex_pick_dw = $signed({2'b00, ex_pick_d});
    if (en_pick_n > 0) begin
      en_num_d = en_pick_n;
      en_den_d = en_pick_d;
    end else begin
      en_num_d = '0;
      en_den_d = N'(1);
    end
    if (ex_pick_n < ex_pick_dw) begin
      ex_num_d = ex_pick_n;
      ex_den_d = ex_pick_d;
    end else begin
      ex_num_d = NW'(1);
      ex_den_d = N'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    xa_o     <= xa2_q;
    ya_o     <= ya2_q;
    dx_o     <= dx2_q;
    dy_o     <= dy2_q;
    en_num_q <= en_num_d;
    en_den_q <= en_den_d;
    ex_num_q <= ex_num_d;
    ex_den_q <= ex_den_d;
  end

  assign ctrl_o   = ctrl_q;
  assign en_num_o = en_num_q;
  assign en_den_o = en_den_q;
  assign ex_num_o = ex_num_q;
  assign ex_den_o = ex_den_q;

  `include "assert_macros.svh"

  `ASSERT_IMPLY(a_ratio_bounds, clk_i, rst_ni, ctrl_q.valid, (en_den_q != '0) && (ex_den_q != '0) && (en_num_q >= 0) && (ex_num_q <= $signed(NW'(ex_den_q))))

endmodule

`default_nettype wire

// File: rtl/lsw_div.sv
// Pipelined restoring divider: one quotient bit per stage, magnitude in,
// magnitude out, sign carried alongside. No package dependency.
`default_nettype none

module lsw_div #(
  parameter int unsigned MW = 29,
  parameter int unsigned DW = 12,
  parameter int unsigned QB = 12
) (
  input  logic          clk_i,
  input  logic [MW-1:0] mag_i,
  input  logic [DW-1:0] den_i,
  input  logic          neg_i,
  output logic [QB-1:0] quo_o,
  output logic          neg_o
);

  logic [MW-1:0] rem_q [QB];
  logic [QB-1:0] quo_q [QB];
  logic [DW-1:0] den_q [QB];
  logic          neg_q [QB];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic [MW-1:0] rem_in, sub;
    logic [QB-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic          neg_in, fit;

    if (j == 0) begin : g_first
      assign rem_in = mag_i;
      assign quo_in = '0;
      assign den_in = den_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign den_in = den_q[j-1];
      assign neg_in = neg_q[j-1];
    end

    // Most significant quotient bit first.
    assign sub = MW'(den_in) << (QB - 1 - j);
    assign fit = rem_in >= sub;

    always_ff @(posedge clk_i) begin
      rem_q[j] <= fit ? rem_in - sub : rem_in;
      quo_q[j] <= quo_in | (fit ? (QB'(1) << (QB - 1 - j)) : '0);
      den_q[j] <= den_in;
      neg_q[j] <= neg_in;
    end
  end

  assign quo_o = quo_q[QB-1];
  assign neg_o = neg_q[QB-1];

endmodule

`default_nettype wire

// File: rtl/line_segment_window_clip.sv
// Segment clipper top level: window registers, final compare, endpoint
// numerators, dividers and result register. Depends on lsw_pkg, lsw_edge,
// lsw_ratio and lsw_div.
//
// Takes one segment per clock whenever start is high (busy stays low) and
// returns its result as a one-cycle done_o strobe; the receiver cannot stall.
// The pipeline is the endpoint dividers, one row per quotient bit (COORD_BITS
// rows), plus six stages of edge terms, ratio selection, cross-multiplication
// and numerator forming. Rejected segments report visible_o low with all
// coordinates zero. The user must write window registers only while no
// segment is in flight, via cfg_we_i/cfg_idx_i/cfg_data_i; it is not enforced.
`default_nettype none

module line_segment_window_clip #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  start_x_i,
  input  logic signed [COORD_BITS-1:0]  start_y_i,
  input  logic signed [COORD_BITS-1:0]  end_x_i,
  input  logic signed [COORD_BITS-1:0]  end_y_i,
  input  logic                          cfg_we_i,
  input  logic [lsw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]         cfg_data_i,
  output logic                          done_o,
  output logic                          visible_o,
  output logic signed [COORD_BITS-1:0]  clip_x0_o,
  output logic signed [COORD_BITS-1:0]  clip_y0_o,
  output logic signed [COORD_BITS-1:0]  clip_x1_o,
  output logic signed [COORD_BITS-1:0]  clip_y1_o
);
  import lsw_pkg::*;

  localparam int unsigned N   = COORD_BITS;
  localparam int unsigned NW  = N + 2;
  localparam int unsigned PW  = 2 * NW;
  localparam int unsigned SW  = PW + 1;
  localparam int unsigned QB  = N;
  localparam int unsigned LAT = QB + 6;

  logic signed [N-1:0] x_min_q, x_max_q, y_min_q, y_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q <= N'(100);
      x_max_q <= N'(300);
      y_min_q <= N'(100);
      y_max_q <= N'(300);
    end else if (cfg_we_i) begin
      unique case (lsw_reg_e'(cfg_idx_i))
        REG_X_MIN: x_min_q <= cfg_data_i;
        REG_X_MAX: x_max_q <= cfg_data_i;
        REG_Y_MIN: y_min_q <= cfg_data_i;
        REG_Y_MAX: y_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Edge terms
  lsw_ctrl_t            e_ctrl;
  logic signed [N-1:0]  e_xa, e_ya;
  logic signed [N:0]    e_dx, e_dy;
  logic signed [NW-1:0] e_enx, e_exx, e_eny, e_exy;
  logic [N-1:0]         e_dxd, e_dyd;

  lsw_edge #(.N(N)) u_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .xa_i    (start_x_i),
    .ya_i    (start_y_i),
    .xb_i    (end_x_i),
    .yb_i    (end_y_i),
    .x_min_i (x_min_q),
    .x_max_i (x_max_q),
    .y_min_i (y_min_q),
    .y_max_i (y_max_q),
    .ctrl_o  (e_ctrl),
    .xa_o    (e_xa),
    .ya_o    (e_ya),
    .dx_o    (e_dx),
    .dy_o    (e_dy),
    .enx_n_o (e_enx),
    .exx_n_o (e_exx),
    .eny_n_o (e_eny),
    .exy_n_o (e_exy),
    .dx_d_o  (e_dxd),
    .dy_d_o  (e_dyd)
  );

  // Ratio selection
  lsw_ctrl_t            r_ctrl;
  logic signed [N-1:0]  r_xa, r_ya;
  logic signed [N:0]    r_dx, r_dy;
  logic signed [NW-1:0] r_en_num, r_ex_num;
  logic [N-1:0]         r_en_den, r_ex_den;

  lsw_ratio #(.N(N)) u_ratio (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (e_ctrl),
    .xa_i     (e_xa),
    .ya_i     (e_ya),
    .dx_i     (e_dx),
    .dy_i     (e_dy),
    .enx_n_i  (e_enx),
    .exx_n_i  (e_exx),
    .eny_n_i  (e_eny),
    .exy_n_i  (e_exy),
    .dx_d_i   (e_dxd),
    .dy_d_i   (e_dyd),
    .ctrl_o   (r_ctrl),
    .xa_o     (r_xa),
    .ya_o     (r_ya),
    .dx_o     (r_dx),
    .dy_o     (r_dy),
    .en_num_o (r_en_num),
    .en_den_o (r_en_den),
    .ex_num_o (r_ex_num),
    .ex_den_o (r_ex_den)
  );

  // Interval check and endpoint products
  lsw_ctrl_t            ctrl4_q, ctrl5_q;
  lsw_ctrl_t            dctrl_q [QB];
  logic signed [PW-1:0] ce_en_q, ce_ex_q;
  logic [N-1:0]         en_den4_q, ex_den4_q;
  logic signed [NW-1:0] en_den_w, ex_den_w;

  assign en_den_w = $signed({2'b00, r_en_den});
  assign ex_den_w = $signed({2'b00, r_ex_den});

  always_ff @(posedge clk_i) begin
    ce_en_q   <= PW'(r_en_num) * PW'(ex_den_w);
    ce_ex_q   <= PW'(r_ex_num) * PW'(en_den_w);
    en_den4_q <= r_en_den;
    ex_den4_q <= r_ex_den;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl4_q <= '0;
      ctrl5_q <= '0;
      for (int i = 0; i < QB; i++) begin
        dctrl_q[i] <= '0;
      end
    end else begin
      ctrl4_q        <= r_ctrl;
      ctrl5_q.valid  <= ctrl4_q.valid;
      ctrl5_q.reject <= ctrl4_q.reject || (ce_en_q > ce_ex_q);
      dctrl_q[0]     <= ctrl5_q;
      for (int i = 1; i < QB; i++) begin
        dctrl_q[i] <= dctrl_q[i-1];
      end
    end
  end

  lsw_ctrl_t           out_ctrl;
  logic signed [N-1:0] coord_d [4];
  logic signed [N-1:0] coord_q [4];
  logic                done_q, visible_q;

  assign out_ctrl = dctrl_q[QB-1];

  // Ends in order: clipped start x, y, clipped end x, y.
  for (genvar k = 0; k < 4; k++) begin : g_end
    logic signed [NW-1:0] base_w, dlt_w, num_w, den_w;
    logic signed [PW-1:0] base_q, step_q;
    logic signed [SW-1:0] sum_w;
    logic [SW-1:0]        mag_q;
    logic [N-1:0]         den4_w, den5_q;
    logic                 neg_q, div_neg;
    logic [QB-1:0]        quo;
    logic signed [N:0]    res;

    if (k % 2 == 0) begin : g_x
      assign base_w = NW'(r_xa);
      assign dlt_w  = NW'(r_dx);
    end else begin : g_y
      assign base_w = NW'(r_ya);
      assign dlt_w  = NW'(r_dy);
    end

    if (k < 2) begin : g_entry
      assign num_w  = r_en_num;
      assign den_w  = en_den_w;
      assign den4_w = en_den4_q;
    end else begin : g_exit
      assign num_w  = r_ex_num;
      assign den_w  = ex_den_w;
      assign den4_w = ex_den4_q;
    end

    always_ff @(posedge clk_i) begin
      base_q <= PW'(base_w) * PW'(den_w);
      step_q <= PW'(dlt_w) * PW'(num_w);
    end

    assign sum_w = SW'(base_q) + SW'(step_q);

    always_ff @(posedge clk_i) begin
      mag_q  <= sum_w[SW-1] ? SW'(-sum_w) : SW'(sum_w);
      neg_q  <= sum_w[SW-1];
      den5_q <= den4_w;
    end

    lsw_div #(.MW(SW), .DW(N), .QB(QB)) u_div (
      .clk_i (clk_i),
      .mag_i (mag_q),
      .den_i (den5_q),
      .neg_i (neg_q),
      .quo_o (quo),
      .neg_o (div_neg)
    );

    // Quotient magnitude truncates toward zero; restore the sign.
    assign res        = div_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    assign coord_d[k] = out_ctrl.reject ? '0 : res[N-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      visible_q <= 1'b0;
    end else begin
      done_q    <= out_ctrl.valid;
      visible_q <= out_ctrl.valid && !out_ctrl.reject;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      coord_q[i] <= coord_d[i];
    end
  end

  assign done_o    = done_q;
  assign visible_o = visible_q;
  assign clip_x0_o = coord_q[0];
  assign clip_y0_o = coord_q[1];
  assign clip_x1_o = coord_q[2];
  assign clip_y1_o = coord_q[3];

  `include "assert_macros.svh"

  `ASSERT_PROP(a_fixed_latency, clk_i, rst_ni, (start && !busy) |-> ##(LAT) done_o)
  `ASSERT_IMPLY(a_visible_strobe, clk_i, rst_ni, visible_o, done_o)
  `ASSERT_IMPLY(a_reject_zero, clk_i, rst_ni, done_o && !visible_o, (clip_x0_o == '0) && (clip_y0_o == '0) && (clip_x1_o == '0) && (clip_y1_o == '0))

endmodule

`default_nettype wire
